// File: hdl/cpa_pkg.sv
package cpa_pkg;

  // Field widths of the request and response transactions
  localparam int unsigned SIZE_W   = 21;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;

  // Request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Response status codes
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FREE_RD,
    ST_SIZE,
    ST_SCAN,
    ST_MARK,
    ST_UNMARK,
    ST_RESP
  } cpa_state_e;

endpackage

// File: hdl/contiguous_page_allocator.sv
// First-fit page allocator. An allocate transaction (kind 0) rounds size_bytes up to whole
// pages and claims the lowest free run of that many pages; a free transaction (kind 1)
// releases the run whose start page it names, using the byte size stored at allocation.
// The occupancy bitmap and the per-run byte sizes live in two single-port-write memories
// with a registered read. After reset the block clears both memories page by page and
// holds in_stall_o high meanwhile. An allocate with zero size goes straight to the
// response; any other allocate runs the pipelined page-count multiply and answers
// STATUS_NOSPACE if the request is larger than the memory, else scans the bitmap page by
// page through its single read port (at most NUM_PAGES pages) and then marks the pages
// of the run. A free reads the stored size, then releases its pages; an index outside
// the memory is answered without either. One transaction is in flight at a time; the
// next is accepted while the previous response waits on out_stall_i.
module contiguous_page_allocator
  import cpa_pkg::*;
#(
  parameter int unsigned NUM_PAGES  = 256,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                kind_i,
  input  logic [SIZE_W-1:0]   size_bytes_i,
  input  logic [IDX_W-1:0]    page_index_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [IDX_W-1:0]    start_page_o,
  output logic [COUNT_W-1:0]  page_count_o
);

  localparam int unsigned AW = $clog2(NUM_PAGES);
  localparam int unsigned CW = $clog2(NUM_PAGES + 1);

  // Memories
  logic              taken_mem [NUM_PAGES];
  logic [SIZE_W-1:0] bytes_mem [NUM_PAGES];

  logic              tk_we, tk_wdata, tk_re, tk_rdata_q;
  logic [AW-1:0]     tk_waddr, tk_raddr;
  logic              rb_we, rb_re;
  logic [AW-1:0]     rb_waddr, rb_raddr;
  logic [SIZE_W-1:0] rb_wdata, rb_rdata_q;

  // Control
  cpa_state_e state_q, state_d;
  logic [CW-1:0] clr_q, clr_d;
  logic [CW-1:0] scan_q, scan_d;
  logic [CW-1:0] cand_q, cand_d;
  logic [CW-1:0] run_q, run_d;
  logic [CW-1:0] rd_page_q, rd_page_d;
  logic          rd_vld_q, rd_vld_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          kind_q, kind_d;
  logic [SIZE_W-1:0] size_q, size_d;

  // Pending result and output register
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [IDX_W-1:0]    res_start_q, res_start_d;
  logic [COUNT_W-1:0]  res_count_q, res_count_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [IDX_W-1:0]    out_start_q, out_start_d;
  logic [COUNT_W-1:0]  out_count_q, out_count_d;

  // Divider
  logic              div_start, div_done;
  logic [SIZE_W-1:0] div_dividend, div_pages;

  // Helpers
  logic [CW-1:0] avail;
  logic [CW-1:0] free_n;
  logic          run_end_over;

  cpa_div #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .done_o     (div_done),
    .pages_o    (div_pages)
  );

  // Bitmap memory
  always_ff @(posedge clk_i) begin
    if (tk_we) begin
      taken_mem[tk_waddr] <= tk_wdata;
    end
    if (tk_re) begin
      tk_rdata_q <= taken_mem[tk_raddr];
    end
  end

  // Run size memory
  always_ff @(posedge clk_i) begin
    if (rb_we) begin
      bytes_mem[rb_waddr] <= rb_wdata;
    end
    if (rb_re) begin
      rb_rdata_q <= bytes_mem[rb_raddr];
    end
  end

  // Pages left from the freed start to the end of memory, and the clipped count
  assign avail  = CW'(NUM_PAGES) - idx_q;
  assign free_n = (div_pages > SIZE_W'(avail)) ? avail : CW'(div_pages);

  // A taken page pushes the candidate start past it; fail once the run cannot fit
  assign run_end_over = ({1'b0, rd_page_q} + (CW + 1)'(1) + {1'b0, n_q})
                        > (CW + 1)'(NUM_PAGES);

  // Next state and datapath control
  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    scan_d       = scan_q;
    cand_d       = cand_q;
    run_d        = run_q;
    rd_page_d    = rd_page_q;
    rd_vld_d     = 1'b0;
    k_d          = k_q;
    n_d          = n_q;
    idx_d        = idx_q;
    kind_d       = kind_q;
    size_d       = size_q;
    res_status_d = res_status_q;
    res_start_d  = res_start_q;
    res_count_d  = res_count_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_start_d  = out_start_q;
    out_count_d  = out_count_q;
    tk_we        = 1'b0;
    tk_waddr     = '0;
    tk_wdata     = 1'b0;
    tk_re        = 1'b0;
    tk_raddr     = '0;
    rb_we        = 1'b0;
    rb_waddr     = '0;
    rb_wdata     = '0;
    rb_re        = 1'b0;
    rb_raddr     = '0;
    div_start    = 1'b0;
    div_dividend = size_bytes_i;

    // Output taken by the consumer
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      // Zero both memories after reset
      ST_CLEAR: begin
        tk_we    = 1'b1;
        tk_waddr = clr_q[AW-1:0];
        rb_we    = 1'b1;
        rb_waddr = clr_q[AW-1:0];
        clr_d    = clr_q + CW'(1);
        if (clr_q == CW'(NUM_PAGES - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d = kind_i;
          size_d = size_bytes_i;
          if (kind_i == KIND_ALLOC) begin
            if (size_bytes_i == '0) begin
              res_status_d = STATUS_ZERO;
              res_start_d  = '0;
              res_count_d  = '0;
              state_d      = ST_RESP;
            end else begin
              div_start = 1'b1;
              state_d   = ST_SIZE;
            end
          end else begin
            res_status_d = STATUS_OK;
            res_start_d  = page_index_i;
            res_count_d  = '0;
            if (32'(page_index_i) < NUM_PAGES) begin
              idx_d    = CW'(page_index_i);
              rb_re    = 1'b1;
              rb_raddr = AW'(page_index_i);
              state_d  = ST_FREE_RD;
            end else begin
              state_d = ST_RESP;
            end
          end
        end
      end

      // Stored size is back: size it and zero the entry
      ST_FREE_RD: begin
        div_start    = 1'b1;
        div_dividend = rb_rdata_q;
        rb_we        = 1'b1;
        rb_waddr     = idx_q[AW-1:0];
        rb_wdata     = '0;
        state_d      = ST_SIZE;
      end

      ST_SIZE: begin
        if (div_done) begin
          if (kind_q == KIND_ALLOC) begin
            if (div_pages > SIZE_W'(NUM_PAGES)) begin
              res_status_d = STATUS_NOSPACE;
              res_start_d  = '0;
              res_count_d  = '0;
              state_d      = ST_RESP;
            end else begin
              n_d     = CW'(div_pages);
              scan_d  = '0;
              cand_d  = '0;
              run_d   = '0;
              state_d = ST_SCAN;
            end
          end else begin
            if (free_n == '0) begin
              state_d = ST_RESP;
            end else begin
              n_d     = free_n;
              k_d     = '0;
              state_d = ST_UNMARK;
            end
          end
        end
      end

      // Stream bitmap reads, one page per cycle, tracking the current free run
      ST_SCAN: begin
        if (32'(scan_q) < NUM_PAGES) begin
          tk_re     = 1'b1;
          tk_raddr  = scan_q[AW-1:0];
          scan_d    = scan_q + CW'(1);
          rd_vld_d  = 1'b1;
          rd_page_d = scan_q;
        end
        if (rd_vld_q) begin
          if (tk_rdata_q) begin
            cand_d = rd_page_q + CW'(1);
            run_d  = '0;
            if (run_end_over) begin
              res_status_d = STATUS_NOSPACE;
              res_start_d  = '0;
              res_count_d  = '0;
              state_d      = ST_RESP;
            end
          end else begin
            run_d = run_q + CW'(1);
            if ((run_q + CW'(1)) == n_q) begin
              k_d     = '0;
              state_d = ST_MARK;
            end
          end
        end
      end

      // Claim the run, store the byte size at its start
      ST_MARK: begin
        tk_we    = 1'b1;
        tk_waddr = AW'(cand_q + k_q);
        tk_wdata = 1'b1;
        if (k_q == '0) begin
          rb_we    = 1'b1;
          rb_waddr = cand_q[AW-1:0];
          rb_wdata = size_q;
        end
        k_d = k_q + CW'(1);
        if (k_q == (n_q - CW'(1))) begin
          res_status_d = STATUS_OK;
          res_start_d  = IDX_W'(cand_q);
          res_count_d  = COUNT_W'(n_q);
          state_d      = ST_RESP;
        end
      end

      // Release the run
      ST_UNMARK: begin
        tk_we    = 1'b1;
        tk_waddr = AW'(idx_q + k_q);
        tk_wdata = 1'b0;
        k_d      = k_q + CW'(1);
        if (k_q == (n_q - CW'(1))) begin
          res_count_d = COUNT_W'(n_q);
          state_d     = ST_RESP;
        end
      end

      // Hand the result to the output register once it is free
      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_start_d  = res_start_q;
          out_count_d  = res_count_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    cand_q       <= cand_d;
    run_q        <= run_d;
    rd_page_q    <= rd_page_d;
    k_q          <= k_d;
    n_q          <= n_d;
    idx_q        <= idx_d;
    kind_q       <= kind_d;
    size_q       <= size_d;
    res_status_q <= res_status_d;
    res_start_q  <= res_start_d;
    res_count_q  <= res_count_d;
    out_status_q <= out_status_d;
    out_start_q  <= out_start_d;
    out_count_q  <= out_count_d;
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign start_page_o = out_start_q;
  assign page_count_o = out_count_q;

endmodule

// File: hdl/cpa_div.sv
// Page count: pages = ceil(bytes / PAGE_BYTES) by reciprocal multiplication.
// Two pipeline stages: done_o rises after start_i has passed through sum_vld_q and done_q.
module cpa_div
  import cpa_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SIZE_W-1:0] dividend_i,
  output logic              done_o,
  output logic [SIZE_W-1:0] pages_o
);

  // Biased dividend width, shift and multiplier width for an exact floor quotient
  localparam int unsigned   XW    = SIZE_W + 1;
  localparam int unsigned   SH    = XW + $clog2(PAGE_BYTES);
  localparam int unsigned   MW    = XW + 2;
  localparam int unsigned   PW    = XW + MW;
  localparam logic [63:0]   RECIP = ((64'd1 << SH) / 64'(PAGE_BYTES)) + 64'd1;
  localparam logic [MW-1:0] MULT  = RECIP[MW-1:0];
  localparam logic [XW-1:0] ROUND = XW'(PAGE_BYTES - 1);

  logic [XW-1:0] sum_q, sum_d;
  logic          sum_vld_q;
  logic [PW-1:0] prod_q, prod_d;
  logic          done_q;

  // Bias by PAGE_BYTES - 1 so the floor quotient rounds up, then scale
  assign sum_d  = start_i ? ({1'b0, dividend_i} + ROUND) : sum_q;
  assign prod_d = {{MW{1'b0}}, sum_q} * {{XW{1'b0}}, MULT};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      sum_vld_q <= start_i;
      done_q    <= sum_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    prod_q <= prod_d;
  end

  assign done_o  = done_q;
  assign pages_o = SIZE_W'(prod_q >> SH);

endmodule
